>>> sv/apl1_pkg.sv
// Shared types, decode mode codes and character tables for the Latin-1 text converter.
package apl1_pkg;

  localparam logic [3:0] MODE_NORMAL = 4'd0;
  localparam logic [3:0] MODE_ACCENT = 4'd1;
  localparam logic [3:0] MODE_GRAVE  = 4'd2;
  localparam logic [3:0] MODE_ACUTE  = 4'd3;
  localparam logic [3:0] MODE_CIRC   = 4'd4;
  localparam logic [3:0] MODE_DIAER  = 4'd5;
  localparam logic [3:0] MODE_CEDIL  = 4'd6;
  localparam logic [3:0] MODE_ESC    = 4'd7;
  localparam logic [3:0] MODE_CUR1   = 4'd8;
  localparam logic [3:0] MODE_CUR2   = 4'd9;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] PFX_ACCENT  = 8'h16;
  localparam logic [7:0] PFX_ESC     = 8'h1B;
  localparam logic [7:0] PFX_CURSOR  = 8'h1F;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_HASH     = 8'h23;
  localparam logic [7:0] CH_QMARK    = 8'h3F;

  localparam logic [7:0] VOWEL_CODES [10] = '{
    8'h61, 8'h65, 8'h69, 8'h6F, 8'h75, 8'h41, 8'h45, 8'h49, 8'h4F, 8'h55
  };

  localparam logic [7:0] VOWEL_MARKS [4][10] = '{
    '{8'hE0, 8'hE8, 8'hEC, 8'hF2, 8'hF9, 8'hC0, 8'hC8, 8'hCC, 8'hD2, 8'hD9},
    '{8'hE1, 8'hE9, 8'hED, 8'hF3, 8'hFA, 8'hC1, 8'hC9, 8'hCD, 8'hD3, 8'hDA},
    '{8'hE2, 8'hEA, 8'hEE, 8'hF4, 8'hFB, 8'hC2, 8'hCA, 8'hCE, 8'hD4, 8'hDB},
    '{8'hE4, 8'hEB, 8'hEF, 8'hF6, 8'hFC, 8'hC4, 8'hCB, 8'hCF, 8'hD6, 8'hDC}
  };

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_text;
    logic       last;
  } word_t;

  typedef struct packed {
    logic [1:0] cnt;
    word_t      w0;
    word_t      w1;
    logic [3:0] mode_next;
  } dec_t;

endpackage

>>> sv/apl1_if.sv
// Valid/ready channel interfaces for source text bytes and converted bytes.
interface apl1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
  modport monitor (input valid, input in_byte, input ready);
endinterface

interface apl1_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_text;
  logic       last;

  modport source (output valid, output out_byte, output end_of_text, output last,
                  input ready);
  modport sink (input valid, input out_byte, input end_of_text, input last,
                output ready);
  modport monitor (input valid, input out_byte, input end_of_text, input last,
                   input ready);
endinterface

>>> sv/apl1_dec.sv
// Combinational decode of one source byte against the current decode mode.
module apl1_dec (
  input  logic [3:0]    mode,
  input  logic [7:0]    c,
  output apl1_pkg::dec_t dec
);

  function automatic logic [7:0] plain_byte(input logic [7:0] b);
    logic [7:0] r;
    if (b == 8'h60) r = 8'hAD;
    else if (b == 8'h7E) r = 8'hAF;
    else if (b == 8'h7F) r = apl1_pkg::CH_SPACE;
    else if (b >= 8'h20 && b < 8'h80) r = b;
    else r = apl1_pkg::CH_QMARK;
    return r;
  endfunction

  function automatic logic [7:0] marked_letter(input logic [3:0] kind, input logic [7:0] b);
    logic [7:0] r;
    logic [3:0] diff;
    logic [1:0] row;
    diff = kind - apl1_pkg::MODE_GRAVE;
    row  = diff[1:0];
    r    = plain_byte(b);
    if (kind == apl1_pkg::MODE_CEDIL) begin
      if (b == 8'h63) r = 8'hE7;
      else if (b == 8'h43) r = 8'hC7;
    end else begin
      for (int k = 0; k < 10; k++) begin
        if (apl1_pkg::VOWEL_CODES[k] == b) r = apl1_pkg::VOWEL_MARKS[row][k];
      end
    end
    return r;
  endfunction

  always_comb begin
    dec           = '0;
    dec.mode_next = apl1_pkg::MODE_NORMAL;
    if (c == apl1_pkg::CH_NUL) begin
      dec.cnt            = 2'd1;
      dec.w0.end_of_text = 1'b1;
    end else begin
      unique case (mode)
        apl1_pkg::MODE_ACCENT: begin
          unique case (c)
            8'h41: dec.mode_next = apl1_pkg::MODE_GRAVE;
            8'h42: dec.mode_next = apl1_pkg::MODE_ACUTE;
            8'h43: dec.mode_next = apl1_pkg::MODE_CIRC;
            8'h48: dec.mode_next = apl1_pkg::MODE_DIAER;
            8'h4B: dec.mode_next = apl1_pkg::MODE_CEDIL;
            8'h23: begin dec.cnt = 2'd1; dec.w0.out_byte = 8'hA3; end
            8'h24: begin dec.cnt = 2'd1; dec.w0.out_byte = 8'h24; end
            8'h26: begin dec.cnt = 2'd1; dec.w0.out_byte = 8'h23; end
            8'h2C: begin
              dec.cnt = 2'd2; dec.w0.out_byte = 8'h3C; dec.w1.out_byte = 8'h2D;
            end
            8'h2D: begin dec.cnt = 2'd1; dec.w0.out_byte = 8'h5E; end
            8'h2E: begin
              dec.cnt = 2'd2; dec.w0.out_byte = 8'h2D; dec.w1.out_byte = 8'h3E;
            end
            8'h2F: begin dec.cnt = 2'd1; dec.w0.out_byte = 8'h56; end
            8'h30: begin dec.cnt = 2'd1; dec.w0.out_byte = 8'hB0; end
            8'h31: begin dec.cnt = 2'd1; dec.w0.out_byte = 8'hB1; end
            8'h38: begin dec.cnt = 2'd1; dec.w0.out_byte = 8'hF7; end
            8'h3C: begin dec.cnt = 2'd1; dec.w0.out_byte = 8'hBC; end
            8'h3D: begin dec.cnt = 2'd1; dec.w0.out_byte = 8'hBD; end
            8'h3E: begin dec.cnt = 2'd1; dec.w0.out_byte = 8'hBE; end
            8'h6A: begin
              dec.cnt = 2'd2; dec.w0.out_byte = 8'h4F; dec.w1.out_byte = 8'h45;
            end
            8'h7A: begin
              dec.cnt = 2'd2; dec.w0.out_byte = 8'h6F; dec.w1.out_byte = 8'h65;
            end
            8'h7B: begin dec.cnt = 2'd1; dec.w0.out_byte = 8'hDF; end
            8'h27: begin dec.cnt = 2'd1; dec.w0.out_byte = 8'hA7; end
            default: ;  // drop unknown accent codes
          endcase
        end
        apl1_pkg::MODE_GRAVE, apl1_pkg::MODE_ACUTE, apl1_pkg::MODE_CIRC,
        apl1_pkg::MODE_DIAER, apl1_pkg::MODE_CEDIL: begin
          dec.cnt         = 2'd1;
          dec.w0.out_byte = marked_letter(mode, c);
        end
        apl1_pkg::MODE_ESC: begin
          if (c == apl1_pkg::CH_SPACE || c == apl1_pkg::CH_HASH) begin
            dec.mode_next = apl1_pkg::MODE_ESC;
          end
        end
        apl1_pkg::MODE_CUR1: dec.mode_next = apl1_pkg::MODE_CUR2;
        apl1_pkg::MODE_CUR2: dec.mode_next = apl1_pkg::MODE_NORMAL;
        default: begin
          if (c == apl1_pkg::PFX_ACCENT) begin
            dec.mode_next = apl1_pkg::MODE_ACCENT;
          end else if (c == apl1_pkg::PFX_ESC) begin
            dec.mode_next = apl1_pkg::MODE_ESC;
          end else if (c == apl1_pkg::PFX_CURSOR) begin
            dec.mode_next = apl1_pkg::MODE_CUR1;
          end else begin
            dec.cnt         = 2'd1;
            dec.w0.out_byte = plain_byte(c);
          end
        end
      endcase
    end
    // mark the final word of this byte
    dec.w0.last = (dec.cnt == 2'd1);
    dec.w1.last = 1'b1;
  end

endmodule

>>> sv/apl1_oq.sv
// Three-entry shift queue of result words that drives the output channel.
module apl1_oq (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      push_cnt,
  input  apl1_pkg::word_t w0,
  input  apl1_pkg::word_t w1,
  output logic            room,
  apl1_out_if.source      dst
);

  localparam int Depth = 3;

  logic [1:0]      cnt;
  logic [1:0]      cnt_next;
  logic [1:0]      base;
  logic            pop;
  apl1_pkg::word_t ent      [Depth];
  apl1_pkg::word_t ent_next [Depth];

  always_comb begin
    pop      = (cnt != 2'd0) && dst.ready;
    base     = cnt - {1'b0, pop};
    ent_next = ent;
    // advance the queue toward the head on a pop
    if (pop) begin
      for (int i = 0; i < Depth - 1; i++) ent_next[i] = ent[i + 1];
    end
    for (int i = 0; i < Depth; i++) begin
      if (push_cnt != 2'd0 && 2'(i) == base) ent_next[i] = w0;
      if (push_cnt == 2'd2 && 2'(i) == base + 2'd1) ent_next[i] = w1;
    end
    cnt_next = base + push_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

  // room for a two-word byte even without a pop this cycle
  assign room            = (cnt <= 2'd1);
  assign dst.valid       = (cnt != 2'd0);
  assign dst.out_byte    = ent[0].out_byte;
  assign dst.end_of_text = ent[0].end_of_text;
  assign dst.last        = ent[0].last;

endmodule

>>> sv/accent_prefix_text_to_latin1.sv
// Result words pass through the registered result queue before they appear on dst.
// Throughput: one source byte per cycle; a byte that yields two words puts both on dst
//   in turn, and src.ready drops while the result queue holds more than one word.
// Reset (rst, synchronous, active high): decode mode returns to normal text and
//   the result queue empties; no words are pending after reset.
module accent_prefix_text_to_latin1 (
  input logic        clk,
  input logic        rst,
  apl1_in_if.sink    src,
  apl1_out_if.source dst
);

  logic [3:0]      mode;
  logic            accept;
  logic            room;
  logic [1:0]      push_cnt;
  apl1_pkg::dec_t  dec;

  // Prefix sequence tracking: 0x16 accent, 0x1B escape, 0x1F cursor.
  // The mode only moves when a source word is actually taken.
  assign accept = src.valid && src.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= apl1_pkg::MODE_NORMAL;
    end else if (accept) begin
      mode <= dec.mode_next;
    end
  end

  // Decode the incoming byte straight off the channel; all the mapping
  // (plain remap, accent letters, symbol codes, end of text) is one short
  // combinational pass.
  apl1_dec u_dec (
    .mode (mode),
    .c    (src.in_byte),
    .dec  (dec)
  );

  // Push zero, one or two words into the result queue; the queue register
  // parts the two channels so src keeps flowing while dst stalls briefly.
  assign push_cnt  = accept ? dec.cnt : 2'd0;
  assign src.ready = room;

  apl1_oq u_oq (
    .clk      (clk),
    .rst      (rst),
    .push_cnt (push_cnt),
    .w0       (dec.w0),
    .w1       (dec.w1),
    .room     (room),
    .dst      (dst)
  );

endmodule

>>> sv/apl1_chk.sv
// Port-level checker for the Latin-1 text converter, bound to the top level.
module apl1_chk (
  input logic       clk,
  input logic       rst,
  input logic       src_valid,
  input logic       src_ready,
  input logic [7:0] src_in_byte,
  input logic       dst_valid,
  input logic       dst_ready,
  input logic [7:0] dst_out_byte,
  input logic       dst_end_of_text,
  input logic       dst_last
);

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !dst_valid)
    else $error("result pending after reset");

  // end-of-text word carries a zero byte and closes its byte
  a_eot_word: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_end_of_text |-> dst_out_byte == 8'h00 && dst_last)
    else $error("malformed end-of-text word");

  // a zero byte taken into an empty block shows up as end of text next cycle
  a_eot_latency: assert property (@(posedge clk) disable iff (rst)
    !dst_valid && src_valid && src_ready && src_in_byte == 8'h00
    |=> dst_valid && dst_end_of_text)
    else $error("end of text not delivered");

  // nothing appears on dst without a source word
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    !dst_valid && !(src_valid && src_ready) |=> !dst_valid)
    else $error("result word without source word");

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_ready |=> dst_valid && $stable(dst_out_byte) && $stable(dst_last))
    else $error("stalled result word changed");

endmodule

bind accent_prefix_text_to_latin1 apl1_chk u_apl1_chk (
  .clk             (clk),
  .rst             (rst),
  .src_valid       (src.valid),
  .src_ready       (src.ready),
  .src_in_byte     (src.in_byte),
  .dst_valid       (dst.valid),
  .dst_ready       (dst.ready),
  .dst_out_byte    (dst.out_byte),
  .dst_end_of_text (dst.end_of_text),
  .dst_last        (dst.last)
);
